// File: rtl/u8sd_pkg.sv
package u8sd_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_INCOMPLETE = 2'd1,
    ST_BAD        = 2'd2,
    ST_RANGE      = 2'd3
  } status_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_UTF16_OUTPUT = 1'b0,
    REG_STRIP_BOM    = 1'b1
  } cfg_reg_t;

  localparam int CodeW      = 31;
  localparam int LenW       = 3;
  localparam int QueueDepth = 4;
  localparam int QPtrW      = 2;
  localparam int QCountW    = 3;

  localparam logic [CodeW-1:0] BOM_CODE   = 31'h0000_feff;
  localparam logic [CodeW-1:0] UNI_MAX    = 31'h0010_ffff;
  localparam logic [CodeW-1:0] SUPP_BASE  = 31'h0001_0000;
  localparam logic [5:0]       HI_SURR_TAG = 6'b110110;
  localparam logic [5:0]       LO_SURR_TAG = 6'b110111;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       string_end;
  } in_t;

  typedef struct packed {
    logic [CodeW-1:0] code_value;
    status_t          status;
    logic [LenW-1:0]  seq_bytes;
    logic             last_of_run;
  } out_t;

  typedef struct packed {
    logic utf16_output;
    logic strip_bom;
  } cfg_t;

  // Up to two results produced by one byte
  typedef struct packed {
    out_t       first;
    out_t       second;
    logic [1:0] count;
  } dec_res_t;

endpackage

// File: rtl/u8sd_decode.sv
module u8sd_decode (
  input  logic              clk,
  input  logic              rst,
  input  u8sd_pkg::in_t     item,
  input  logic              fire,
  input  u8sd_pkg::cfg_t    cfg,
  output u8sd_pkg::dec_res_t res
);
  import u8sd_pkg::*;

  logic [CodeW-1:0] partial_code;
  logic [LenW-1:0]  bytes_owed;
  logic [LenW-1:0]  seq_length;
  logic             error_latched;
  logic             at_string_start;

  logic [CodeW-1:0] partial_code_next;
  logic [LenW-1:0]  bytes_owed_next;
  logic [LenW-1:0]  seq_length_next;
  logic             error_latched_next;
  logic             at_string_start_next;

  logic [CodeW-1:0] code_val;
  logic [LenW-1:0]  char_len;
  logic             done;
  status_t          err;
  logic [20:0]      sur_off;
  logic [7:0]       b;

  assign b       = item.data_byte;
  assign sur_off = code_val[20:0] - SUPP_BASE[20:0];

  // Decode one byte against the sequence state and form its results.
  always_comb begin
    partial_code_next    = partial_code;
    bytes_owed_next      = bytes_owed;
    seq_length_next      = seq_length;
    error_latched_next   = error_latched;
    at_string_start_next = at_string_start;
    code_val             = partial_code;
    char_len             = seq_length;
    done                 = 1'b0;
    err                  = ST_OK;
    res                  = '0;

    if (!error_latched) begin
      if (bytes_owed == '0) begin
        // Lead byte: its prefix gives the sequence length.
        if (b[7] == 1'b0) begin
          partial_code_next = {23'd0, b};
          seq_length_next   = 3'd1;
          done              = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          partial_code_next = {26'd0, b[4:0]};
          bytes_owed_next   = 3'd1;
          seq_length_next   = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
          partial_code_next = {27'd0, b[3:0]};
          bytes_owed_next   = 3'd2;
          seq_length_next   = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
          partial_code_next = {28'd0, b[2:0]};
          bytes_owed_next   = 3'd3;
          seq_length_next   = 3'd4;
        end else if (b[7:2] == 6'b111110) begin
          partial_code_next = {29'd0, b[1:0]};
          bytes_owed_next   = 3'd4;
          seq_length_next   = 3'd5;
        end else if (b[7:1] == 7'b1111110) begin
          partial_code_next = {30'd0, b[0]};
          bytes_owed_next   = 3'd5;
          seq_length_next   = 3'd6;
        end else begin
          err = ST_BAD;
        end
      end else if (b[7:6] != 2'b10) begin
        err = ST_BAD;
      end else begin
        // Continuation byte: shift in six more bits.
        partial_code_next = {partial_code[24:0], b[5:0]};
        bytes_owed_next   = bytes_owed - 3'd1;
        done              = (bytes_owed == 3'd1);
      end

      if (err == ST_OK && !done && item.string_end && bytes_owed_next != '0) begin
        err = ST_INCOMPLETE;
      end

      if (err == ST_OK && done) begin
        code_val             = partial_code_next;
        char_len             = seq_length_next;
        at_string_start_next = 1'b0;
        partial_code_next    = '0;
        seq_length_next      = '0;
        if (at_string_start && cfg.strip_bom && code_val == BOM_CODE) begin
          res.count = 2'd0;
        end else if (!cfg.utf16_output) begin
          res.first = '{code_value: code_val, status: ST_OK, seq_bytes: char_len,
                        last_of_run: 1'b1};
          res.count = 2'd1;
        end else if (code_val > UNI_MAX) begin
          err = ST_RANGE;
        end else if (code_val >= SUPP_BASE) begin
          // Surrogate pair: high word then low word.
          res.first  = '{code_value: {15'd0, HI_SURR_TAG, sur_off[19:10]},
                         status: ST_OK, seq_bytes: char_len, last_of_run: 1'b0};
          res.second = '{code_value: {15'd0, LO_SURR_TAG, sur_off[9:0]},
                         status: ST_OK, seq_bytes: char_len, last_of_run: 1'b1};
          res.count  = 2'd2;
        end else begin
          res.first = '{code_value: code_val, status: ST_OK, seq_bytes: char_len,
                        last_of_run: 1'b1};
          res.count = 2'd1;
        end
      end

      // The first error of a string gives one result and latches.
      if (err != ST_OK) begin
        res.first = '{code_value: '0, status: err, seq_bytes: '0, last_of_run: 1'b1};
        res.second             = '0;
        res.count              = 2'd1;
        error_latched_next     = 1'b1;
        partial_code_next      = '0;
        bytes_owed_next        = '0;
        seq_length_next        = '0;
        at_string_start_next   = 1'b0;
      end
    end

    // Every string end returns to the start state.
    if (item.string_end) begin
      partial_code_next    = '0;
      bytes_owed_next      = '0;
      seq_length_next      = '0;
      error_latched_next   = 1'b0;
      at_string_start_next = 1'b1;
    end
  end

  // Sequence state advances once per decoded byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_code    <= '0;
      bytes_owed      <= '0;
      seq_length      <= '0;
      error_latched   <= 1'b0;
      at_string_start <= 1'b1;
    end else if (fire) begin
      partial_code    <= partial_code_next;
      bytes_owed      <= bytes_owed_next;
      seq_length      <= seq_length_next;
      error_latched   <= error_latched_next;
      at_string_start <= at_string_start_next;
    end
  end

endmodule

// File: rtl/u8sd_out_queue.sv
module u8sd_out_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  u8sd_pkg::dec_res_t res,
  output logic               room,
  output logic               valid,
  input  logic               ready,
  output u8sd_pkg::out_t     head
);
  import u8sd_pkg::*;

  out_t               entries [QueueDepth];
  logic [QPtrW-1:0]   wr_ptr;
  logic [QPtrW-1:0]   rd_ptr;
  logic [QCountW-1:0] count;
  logic [1:0]         push_n;
  logic               pop;

  assign push_n = push ? res.count : 2'd0;
  assign pop    = valid && ready;
  assign valid  = (count != '0);
  assign head   = entries[rd_ptr];
  // Room for a surrogate pair is required before a byte is decoded.
  assign room   = (count <= QCountW'(QueueDepth - 2));

  // Result storage: up to two entries written per cycle.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entries[wr_ptr] <= res.first;
    end
    if (push_n == 2'd2) begin
      entries[wr_ptr + QPtrW'(1)] <= res.second;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPtrW'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + QPtrW'(1);
      end
      count <= count + QCountW'(push_n) - QCountW'(pop);
    end
  end

endmodule

// File: rtl/utf8_stream_decoder_core.sv
// A byte transfer is held in the input register and decoded from there once the result
// queue has room; its results are registered in the queue, from which they are offered.
// Throughput: one byte per cycle; a surrogate pair takes two transfers on the result port,
// and the four-entry result queue stalls byte input once it is nearly full.
// Reset (synchronous): clears both registers, the sequence state and the queue.
module utf8_stream_decoder_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           byte_valid,
  output logic           byte_ready,
  input  u8sd_pkg::in_t  byte_data,
  output logic           char_valid,
  input  logic           char_ready,
  output u8sd_pkg::out_t char_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [0:0]     cfg_index,
  input  logic           cfg_data
);
  import u8sd_pkg::*;

  cfg_t     cfg;
  in_t      in_q;
  logic     in_q_valid;
  logic     room;
  logic     fire;
  dec_res_t res;

  assign cfg_ready  = 1'b1;
  assign fire       = in_q_valid && room;
  assign byte_ready = !in_q_valid || fire;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_UTF16_OUTPUT: cfg.utf16_output <= cfg_data;
        REG_STRIP_BOM:    cfg.strip_bom    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: holds one byte until the queue can take its results.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (byte_ready) begin
      in_q_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      in_q <= byte_data;
    end
  end

  // Byte decoder with its sequence state.
  u8sd_decode u_decode (
    .clk  (clk),
    .rst  (rst),
    .item (in_q),
    .fire (fire),
    .cfg  (cfg),
    .res  (res)
  );

  // Result queue towards the character port.
  u8sd_out_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (fire),
    .res   (res),
    .room  (room),
    .valid (char_valid),
    .ready (char_ready),
    .head  (char_data)
  );

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import u8sd_pkg::*;

  localparam logic [CodeW-1:0] HI_SURR_BASE = 31'h0000_d800;
  localparam logic [CodeW-1:0] LO_SURR_BASE = 31'h0000_dc00;
  localparam logic [CodeW-1:0] SURR_MASK    = 31'h0000_03ff;
  localparam logic [CodeW-1:0] BYTE_MARK    = 31'h0000_003f;
  localparam int               REPORT_CAP   = 40;
  localparam int               SETTLE       = 8;

  typedef enum int {RX_FREE, RX_RANDOM, RX_SPARSE, RX_BURSTY} rx_mode_t;

  // Predicts the decoded characters and checks the result transfers against them.
  class decoded_char_board;
    bit               utf16;
    bit               strip;
    logic [CodeW-1:0] partial;
    logic [LenW-1:0]  owed;
    logic [LenW-1:0]  seq_len;
    bit               err_latched;
    bit               at_start;
    out_t             expected_chars[$];
    int               checked;
    int               failures;
    int               error_results;
    int               pairs;

    function new();
      utf16 = 1'b0;
      strip = 1'b0;
      clear_string();
      checked = 0;
      failures = 0;
      error_results = 0;
      pairs = 0;
    endfunction

    function void clear_string();
      partial = '0;
      owed = '0;
      seq_len = '0;
      err_latched = 1'b0;
      at_start = 1'b1;
    endfunction

    function void set_reg(cfg_reg_t idx, logic val);
      case (idx)
        REG_UTF16_OUTPUT: utf16 = val;
        REG_STRIP_BOM:    strip = val;
        default:          ;
      endcase
    endfunction

    function void push_char(logic [CodeW-1:0] code, status_t st, logic [LenW-1:0] len,
                            logic last);
      out_t r;
      r.code_value = code;
      r.status = st;
      r.seq_bytes = len;
      r.last_of_run = last;
      expected_chars.push_back(r);
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    // Decode one accepted byte and queue the results it causes.
    function void note_byte(in_t item);
      logic [7:0]       b;
      status_t          err;
      bit               done;
      bit               first;
      logic [CodeW-1:0] v;
      logic [CodeW-1:0] d;
      logic [LenW-1:0]  len;
      b = item.data_byte;
      err = ST_OK;
      done = 1'b0;

      // The rest of a string after an error is skipped.
      if (err_latched) begin
        if (item.string_end) clear_string();
        return;
      end

      if (owed == 0) begin
        if (b[7] == 1'b0) begin
          partial = {24'd0, b[6:0]};
          seq_len = 3'd1;
          done = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          partial = {26'd0, b[4:0]};
          owed = 3'd1;
          seq_len = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
          partial = {27'd0, b[3:0]};
          owed = 3'd2;
          seq_len = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
          partial = {28'd0, b[2:0]};
          owed = 3'd3;
          seq_len = 3'd4;
        end else if (b[7:2] == 6'b111110) begin
          partial = {29'd0, b[1:0]};
          owed = 3'd4;
          seq_len = 3'd5;
        end else if (b[7:1] == 7'b1111110) begin
          partial = {30'd0, b[0]};
          owed = 3'd5;
          seq_len = 3'd6;
        end else begin
          err = ST_BAD;
        end
      end else if (b[7:6] != 2'b10) begin
        err = ST_BAD;
      end else begin
        partial = {partial[CodeW-7:0], b[5:0]};
        owed = owed - 3'd1;
        if (owed == 0) done = 1'b1;
      end

      // A string that ends inside a sequence is incomplete.
      if (err == ST_OK && !done && item.string_end && owed != 0) err = ST_INCOMPLETE;

      if (err == ST_OK && done) begin
        v = partial;
        len = seq_len;
        first = at_start;
        at_start = 1'b0;
        partial = '0;
        seq_len = '0;
        if (first && strip && v == BOM_CODE) begin
          // A leading byte order mark is dropped.
        end else if (!utf16) begin
          push_char(v, ST_OK, len, 1'b1);
        end else if (v > UNI_MAX) begin
          err = ST_RANGE;
        end else if (v >= SUPP_BASE) begin
          d = v - SUPP_BASE;
          push_char(HI_SURR_BASE + (d >> 10), ST_OK, len, 1'b0);
          push_char(LO_SURR_BASE + (d & SURR_MASK), ST_OK, len, 1'b1);
          pairs++;
        end else begin
          push_char(v, ST_OK, len, 1'b1);
        end
      end

      if (err != ST_OK) begin
        push_char('0, err, '0, 1'b1);
        error_results++;
        err_latched = 1'b1;
        partial = '0;
        owed = '0;
        seq_len = '0;
        at_start = 1'b0;
      end

      if (item.string_end) clear_string();
    endfunction

    function void flag(string what, logic [CodeW-1:0] want, logic [CodeW-1:0] got);
      failures++;
      if (failures <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    endfunction

    // Compare one result transfer with the oldest prediction.
    function void check_char(out_t got);
      out_t want;
      if (expected_chars.size() == 0) begin
        failures++;
        if (failures <= REPORT_CAP)
          $display("%0t: unexpected result, expected none, got code %h status %0d len %0d",
                   $time, got.code_value, got.status, got.seq_bytes);
        return;
      end
      want = expected_chars.pop_front();
      checked++;
      if (got.code_value !== want.code_value)
        flag("code_value", want.code_value, got.code_value);
      if (got.status !== want.status)
        flag("status", 31'(want.status), 31'(got.status));
      if (got.seq_bytes !== want.seq_bytes)
        flag("seq_bytes", 31'(want.seq_bytes), 31'(got.seq_bytes));
      if (got.last_of_run !== want.last_of_run)
        flag("last_of_run", 31'(want.last_of_run), 31'(got.last_of_run));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_ready;
  in_t        byte_data = '0;
  logic       char_valid;
  logic       char_ready = 1'b0;
  out_t       char_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [0:0] cfg_index = REG_UTF16_OUTPUT;
  logic       cfg_data = 1'b0;

  decoded_char_board board;
  int        sent_count = 0;
  int        burst_left = 0;
  rx_mode_t  rx_mode = RX_FREE;
  int        rx_left = 0;
  int        rx_tick = 0;
  int        rx_hold = 0;

  utf8_stream_decoder_core dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_data  (char_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // Receiver: the stall pattern is picked anew at random among free, random, sparse and bursty.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 300);
    end else begin
      rx_left--;
    end
    rx_tick++;
    case (rx_mode)
      RX_FREE:   char_ready <= 1'b1;
      RX_RANDOM: char_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: char_ready <= (rx_tick % 4 == 0);
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
          char_ready <= 1'b0;
        end else begin
          char_ready <= 1'b1;
          if ($urandom_range(0, 7) == 0) rx_hold = $urandom_range(1, 20);
        end
      end
    endcase
  end

  // Every result transfer is checked at the clock edge that completes it.
  always @(posedge clk) begin
    if (!rst && char_valid && char_ready) board.check_char(char_data);
  end

  // Offer one byte and wait for its transfer; the sender may idle between bursts.
  task automatic send_byte(input in_t item);
    int gap;
    @(negedge clk);
    byte_valid <= 1'b1;
    byte_data <= item;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    board.note_byte(item);
    sent_count++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        byte_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_raw(input logic [7:0] b, input logic ends);
    in_t item;
    item.data_byte = b;
    item.string_end = ends;
    send_byte(item);
  endtask

  // Encode a value in the given sequence length, possibly cut short after count bytes.
  task automatic send_char(input logic [CodeW-1:0] cp, input int len, input int count,
                           input bit ends);
    logic [7:0] b;
    int         k;
    for (k = 0; k < count; k++) begin
      if (k == 0) begin
        case (len)
          1:       b = {1'b0, cp[6:0]};
          2:       b = {3'b110, 5'(cp >> 6)};
          3:       b = {4'b1110, 4'(cp >> 12)};
          4:       b = {5'b11110, 3'(cp >> 18)};
          5:       b = {6'b111110, 2'(cp >> 24)};
          default: b = {7'b1111110, cp[30]};
        endcase
      end else begin
        b = 8'h80 | 8'((cp >> (6 * (len - 1 - k))) & BYTE_MARK);
      end
      send_raw(b, ends && (k == count - 1));
    end
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 1;
    if (r < 50) return 2;
    if (r < 75) return 3;
    if (r < 90) return 4;
    if (r < 95) return 5;
    return 6;
  endfunction

  function automatic logic [CodeW-1:0] rand_code(input int len);
    int          bits;
    logic [31:0] r;
    bits = (len == 1) ? 7 : 5 * len + 1;
    r = $urandom;
    return r[CodeW-1:0] & ((31'd1 << bits) - 31'd1);
  endfunction

  // One string: mostly well-formed characters, with some noise and cut sequences.
  task automatic send_random_string();
    int nchars;
    int i;
    int kind;
    int len;
    bit last_char;
    nchars = $urandom_range(1, 8);
    if ($urandom_range(0, 19) == 0) begin
      for (i = 0; i < nchars; i++) send_raw(8'($urandom), i == nchars - 1);
      return;
    end
    for (i = 0; i < nchars; i++) begin
      last_char = (i == nchars - 1);
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
        send_raw(8'($urandom), last_char);
      end else if (kind < 10) begin
        len = $urandom_range(2, 6);
        send_char(rand_code(len), len, $urandom_range(1, len - 1), last_char);
      end else if (i == 0 && kind < 16) begin
        send_char(BOM_CODE, 3, 3, last_char);
      end else begin
        len = pick_len();
        send_char(rand_code(len), len, len, last_char);
      end
    end
  endtask

  // Hold the sender until every predicted result has arrived and the block has settled.
  task automatic wait_drain();
    @(negedge clk);
    byte_valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic utf16, input logic strip);
    write_reg(REG_UTF16_OUTPUT, utf16);
    write_reg(REG_STRIP_BOM, strip);
  endtask

  // Safety net against a hung handshake.
  initial begin
    #(20_000_000);
    $display("simulation failed");
    $finish;
  end

  initial begin
    bit utf16_plan [5] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    bit strip_plan [5] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
    int phase;
    int target;
    int halfway;
    int spin;
    bit paused;

    board = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: UCS-4 output, smallest value and the largest six-byte value.
    set_config(1'b0, 1'b0);
    send_raw(8'h00, 1'b0);
    send_char(31'h7fff_ffff, 6, 6, 1'b1);
    wait_drain();

    // Directed: UTF-16 output with stripping, edge of Unicode range and each error.
    set_config(1'b1, 1'b1);
    send_char(BOM_CODE, 3, 3, 1'b0);
    send_char(UNI_MAX, 4, 4, 1'b1);
    send_char(UNI_MAX + 31'd1, 4, 4, 1'b1);
    send_raw(8'hfe, 1'b1);
    send_raw(8'hc3, 1'b0);
    send_raw(8'h41, 1'b1);
    send_raw(8'he2, 1'b0);
    send_raw(8'h82, 1'b1);
    send_raw(8'h80, 1'b0);
    send_raw(8'h7f, 1'b1);

    // Random phases, each after a register write from the plan, with one full drain mid-phase.
    for (phase = 0; phase < 5; phase++) begin
      wait_drain();
      set_config(utf16_plan[phase], strip_plan[phase]);
      target = sent_count + 350;
      halfway = sent_count + 175;
      paused = 1'b0;
      while (sent_count < target) begin
        if (!paused && sent_count >= halfway) begin
          wait_drain();
          paused = 1'b1;
        end
        send_random_string();
      end
    end

    // Let the last results come out, within a bound.
    @(negedge clk);
    byte_valid <= 1'b0;
    for (spin = 0; spin < 5000 && board.pending() != 0; spin++) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (board.pending() != 0) begin
      board.failures++;
      $display("%0t: %0d results never arrived, oldest expected code %h", $time,
               board.pending(), board.expected_chars[0].code_value);
    end

    $display("Decoded %0d byte transfers into %0d result transfers (%0d errors, %0d pairs).",
             sent_count, board.checked, board.error_results, board.pairs);
    $display("Both output modes were run with and without byte order mark stripping.");
    if (board.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: utf8_stream_decoder_core.f
rtl/u8sd_pkg.sv
rtl/u8sd_decode.sv
rtl/u8sd_out_queue.sv
rtl/utf8_stream_decoder_core.sv
sim/tb.sv
